>>> hw/rtl/arpr_pkg.sv
// ----------------------------------------------------------------------------
// arpr_pkg
// Shared types and constants of the ARP responder with its hashed binding
// cache: field widths, cache geometry, status codes, sequencer states and the
// structs between the control sequencer and the binding store.
// ----------------------------------------------------------------------------
package arpr_pkg;

   localparam int MAC_W  = 48;
   localparam int IP_W   = 32;
   localparam int LEN_W  = 16;
   localparam int TYPE_W = 16;
   localparam int ALEN_W = 8;
   localparam int OP_W   = 16;

   // Cache geometry. BUCKETS must be a power of two (the bucket is the low
   // bits of the IP).
   localparam int BUCKETS = 64;
   localparam int WAYS    = 4;
   localparam int SLOTS   = BUCKETS * WAYS;
   localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

   // Packet checks
   localparam logic [LEN_W-1:0]  ARP_MIN_LEN = LEN_W'(28);
   localparam logic [TYPE_W-1:0] ETYPE_IPV4  = TYPE_W'(16'h0800);
   localparam logic [ALEN_W-1:0] MAC_LEN     = ALEN_W'(6);
   localparam logic [ALEN_W-1:0] IPV4_LEN    = ALEN_W'(4);
   localparam logic [OP_W-1:0]   OP_REQUEST  = OP_W'(1);
   localparam logic [OP_W-1:0]   OP_REPLY    = OP_W'(2);

   // Command codes
   localparam logic CMD_PACKET = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Configuration register indexes
   localparam logic CSR_OWN_IP  = 1'b0;
   localparam logic CSR_OWN_MAC = 1'b1;

   typedef enum logic [3:0] {
      ST_REPLIED     = 4'd0,
      ST_LEARNED     = 4'd1,
      ST_HIT         = 4'd2,
      ST_MISS        = 4'd3,
      ST_SHORT       = 4'd4,
      ST_NOT_IPV4    = 4'd5,
      ST_BAD_HWLEN   = 4'd6,
      ST_BAD_PLEN    = 4'd7,
      ST_BAD_OP      = 4'd8,
      ST_NO_OWN_IP   = 4'd9,
      ST_NOT_FOR_US  = 4'd10,
      ST_BUCKET_FULL = 4'd11
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_COMPARE,
      SEQ_EMIT
   } seq_state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [IP_W-1:0]   wr_ip;
      logic [MAC_W-1:0]  wr_mac;
      logic [ADDR_W-1:0] rd_addr;
   } store_req_type;

   typedef struct packed {
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } store_rsp_type;

endpackage

>>> hw/rtl/arp_responder_with_hash_cache.sv
// ----------------------------------------------------------------------------
// arp_responder_with_hash_cache
// ARP packet checker and responder with a set-associative IPv4 to MAC cache.
//
//   channel  dir  handshake           carries
//   req_*    in   valid / stall       ARP packet fields or a lookup key
//   rsp_*    out  valid / stall       status, reply fields, found MAC
//   csr_*    in   valid / ready       register index, write data
//
// A packet that fails a check or needs no cache access goes from acceptance
// straight to the emit state. A probe takes a store read then a compare per
// way on the single IP comparator, and stops at a hit or after the last way.
// req_stall is high from acceptance until the result is loaded into the
// output register; a stalled result holds the next one in the sequencer.
// Reset clears every slot's valid bit at once: no clearing pass.
// ----------------------------------------------------------------------------
module arp_responder_with_hash_cache (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [arpr_pkg::LEN_W-1:0]      req_packet_length,
   input  logic [arpr_pkg::TYPE_W-1:0]     req_proto_type,
   input  logic [arpr_pkg::ALEN_W-1:0]     req_hw_len,
   input  logic [arpr_pkg::ALEN_W-1:0]     req_proto_len,
   input  logic [arpr_pkg::OP_W-1:0]       req_opcode,
   input  logic [arpr_pkg::MAC_W-1:0]      req_sender_mac,
   input  logic [arpr_pkg::IP_W-1:0]       req_sender_ip,
   input  logic [arpr_pkg::IP_W-1:0]       req_target_ip,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [3:0]                      rsp_status,
   output logic [arpr_pkg::MAC_W-1:0]      rsp_reply_dest_mac,
   output logic [arpr_pkg::IP_W-1:0]       rsp_reply_target_ip,
   output logic [arpr_pkg::MAC_W-1:0]      rsp_found_mac,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_index,
   input  logic [arpr_pkg::MAC_W-1:0]      csr_wr_data
);
   import arpr_pkg::*;

   logic [IP_W-1:0] own_ip_ff;
   store_req_type   store_req;
   store_rsp_type   store_rsp;

   assign csr_ready = 1'b1;

   // only the own IP is kept; a write to the own MAC index is accepted and dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff <= '0;
      end else if (csr_valid && csr_index == CSR_OWN_IP) begin
         own_ip_ff <= csr_wr_data[IP_W-1:0];
      end
   end

   arpr_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .own_ip              (own_ip_ff),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_packet_length   (req_packet_length),
      .req_proto_type      (req_proto_type),
      .req_hw_len          (req_hw_len),
      .req_proto_len       (req_proto_len),
      .req_opcode          (req_opcode),
      .req_sender_mac      (req_sender_mac),
      .req_sender_ip       (req_sender_ip),
      .req_target_ip       (req_target_ip),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_reply_dest_mac  (rsp_reply_dest_mac),
      .rsp_reply_target_ip (rsp_reply_target_ip),
      .rsp_found_mac       (rsp_found_mac),
      .store_req           (store_req),
      .store_rsp           (store_rsp)
   );

   arpr_store u_store (
      .clock (clock),
      .reset (reset),
      .req   (store_req),
      .rsp   (store_rsp)
   );

   // IP zero marks an empty slot, so it must never be written
   a_no_zero_write: assert property (@(posedge clock) disable iff (reset)
      store_req.wr_en |-> store_req.wr_ip != '0)
      else $error("write of IP zero into binding store");

   // the store is only written while a transaction is in flight
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      store_req.wr_en |-> req_stall)
      else $error("store write while idle");

   // reply fields only carry data when a reply is due
   a_reply_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_REPLIED && rsp_status != ST_BUCKET_FULL
      |-> rsp_reply_dest_mac == '0 && rsp_reply_target_ip == '0)
      else $error("reply fields set without a reply");

   // found MAC only on a hit
   a_found_mac: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_HIT |-> rsp_found_mac == '0)
      else $error("found MAC set without a hit");

endmodule

>>> hw/rtl/arpr_store.sv
// ----------------------------------------------------------------------------
// arpr_store
// Binding store: IP and MAC per slot, one write and one registered read per
// cycle. A per-slot valid bit, cleared by reset, makes unwritten slots read
// as empty (all zero).
// ----------------------------------------------------------------------------
module arpr_store (
   input  logic                   clock,
   input  logic                   reset,
   input  arpr_pkg::store_req_type req,
   output arpr_pkg::store_rsp_type rsp
);
   import arpr_pkg::*;

   logic [IP_W-1:0]  ip_mem  [SLOTS];
   logic [MAC_W-1:0] mac_mem [SLOTS];
   logic [SLOTS-1:0] valid_ff;
   logic [IP_W-1:0]  rd_ip_ff;
   logic [MAC_W-1:0] rd_mac_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            valid_ff[req.wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         ip_mem[req.wr_addr]  <= req.wr_ip;
         mac_mem[req.wr_addr] <= req.wr_mac;
      end
      rd_ip_ff  <= ip_mem[req.rd_addr];
      rd_mac_ff <= mac_mem[req.rd_addr];
   end

   assign rsp.ip  = rd_valid_ff ? rd_ip_ff  : '0;
   assign rsp.mac = rd_valid_ff ? rd_mac_ff : '0;

endmodule

>>> hw/rtl/arpr_ctrl.sv
// ----------------------------------------------------------------------------
// arpr_ctrl
// Sequencer: decodes an accepted transaction; where the cache is needed it
// probes the bucket one way at a time through a single IP comparator, learns
// or looks up, and holds the result in an output register.
// ----------------------------------------------------------------------------
module arpr_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [arpr_pkg::IP_W-1:0]       own_ip,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [arpr_pkg::LEN_W-1:0]      req_packet_length,
   input  logic [arpr_pkg::TYPE_W-1:0]     req_proto_type,
   input  logic [arpr_pkg::ALEN_W-1:0]     req_hw_len,
   input  logic [arpr_pkg::ALEN_W-1:0]     req_proto_len,
   input  logic [arpr_pkg::OP_W-1:0]       req_opcode,
   input  logic [arpr_pkg::MAC_W-1:0]      req_sender_mac,
   input  logic [arpr_pkg::IP_W-1:0]       req_sender_ip,
   input  logic [arpr_pkg::IP_W-1:0]       req_target_ip,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [3:0]                      rsp_status,
   output logic [arpr_pkg::MAC_W-1:0]      rsp_reply_dest_mac,
   output logic [arpr_pkg::IP_W-1:0]       rsp_reply_target_ip,
   output logic [arpr_pkg::MAC_W-1:0]      rsp_found_mac,
   output arpr_pkg::store_req_type         store_req,
   input  arpr_pkg::store_rsp_type         store_rsp
);
   import arpr_pkg::*;

   seq_state_type    state_ff, state_in;
   status_type       status_ff, status_in;
   logic [MAC_W-1:0] rmac_ff, rmac_in;
   logic [IP_W-1:0]  rip_ff, rip_in;
   logic [MAC_W-1:0] fmac_ff, fmac_in;
   logic [IP_W-1:0]  key_ff, key_in;
   logic [MAC_W-1:0] lmac_ff, lmac_in;
   logic             learn_ff, learn_in;
   logic [WAY_W-1:0] way_ff, way_in;
   logic             free_found_ff, free_found_in;
   logic [WAY_W-1:0] free_way_ff, free_way_in;

   logic             out_valid_ff, out_valid_in;
   logic [3:0]       out_status_ff;
   logic [MAC_W-1:0] out_rmac_ff;
   logic [IP_W-1:0]  out_rip_ff;
   logic [MAC_W-1:0] out_fmac_ff;
   logic             out_load;

   logic [ADDR_W-1:0] base;
   logic              hit;
   logic              empty;
   logic              last_way;
   logic              free_now;

   assign base     = ADDR_W'(key_ff % BUCKETS) * ADDR_W'(WAYS);
   assign hit      = (store_rsp.ip == key_ff);
   assign empty    = (store_rsp.ip == '0);
   assign last_way = (way_ff == WAY_W'(WAYS - 1));
   assign free_now = empty && !free_found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      rmac_ff       <= rmac_in;
      rip_ff        <= rip_in;
      fmac_ff       <= fmac_in;
      key_ff        <= key_in;
      lmac_ff       <= lmac_in;
      learn_ff      <= learn_in;
      way_ff        <= way_in;
      free_found_ff <= free_found_in;
      free_way_ff   <= free_way_in;
      if (out_load) begin
         out_status_ff <= status_ff;
         out_rmac_ff   <= rmac_ff;
         out_rip_ff    <= rip_ff;
         out_fmac_ff   <= fmac_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      rmac_in       = rmac_ff;
      rip_in        = rip_ff;
      fmac_in       = fmac_ff;
      key_in        = key_ff;
      lmac_in       = lmac_ff;
      learn_in      = learn_ff;
      way_in        = way_ff;
      free_found_in = free_found_ff;
      free_way_in   = free_way_ff;
      out_load      = 1'b0;
      req_stall     = 1'b1;
      store_req         = '0;
      store_req.rd_addr = base + ADDR_W'(way_ff);
      store_req.wr_addr = base + ADDR_W'(way_ff);
      store_req.wr_ip   = key_ff;
      store_req.wr_mac  = lmac_ff;

      unique case (state_ff)
         SEQ_IDLE: begin
            req_stall     = 1'b0;
            way_in        = '0;
            free_found_in = 1'b0;
            free_way_in   = '0;
            rmac_in       = '0;
            rip_in        = '0;
            fmac_in       = '0;
            key_in        = req_sender_ip;
            lmac_in       = req_sender_mac;
            learn_in      = 1'b1;
            if (req_valid) begin
               state_in = SEQ_EMIT;
               if (req_command == CMD_LOOKUP) begin
                  status_in = ST_MISS;
                  key_in    = req_target_ip;
                  learn_in  = 1'b0;
                  if (req_target_ip != '0) begin
                     state_in = SEQ_READ;
                  end
               end else if (req_packet_length < ARP_MIN_LEN) begin
                  status_in = ST_SHORT;
               end else if (req_proto_type != ETYPE_IPV4) begin
                  status_in = ST_NOT_IPV4;
               end else if (req_hw_len != MAC_LEN) begin
                  status_in = ST_BAD_HWLEN;
               end else if (req_proto_len != IPV4_LEN) begin
                  status_in = ST_BAD_PLEN;
               end else if (req_opcode != OP_REQUEST && req_opcode != OP_REPLY) begin
                  status_in = ST_BAD_OP;
               end else if (own_ip == '0) begin
                  status_in = ST_NO_OWN_IP;
               end else if (req_opcode == OP_REQUEST && req_target_ip != own_ip) begin
                  status_in = ST_NOT_FOR_US;
               end else begin
                  if (req_opcode == OP_REQUEST) begin
                     status_in = ST_REPLIED;
                     rmac_in   = req_sender_mac;
                     rip_in    = req_sender_ip;
                  end else begin
                     status_in = ST_LEARNED;
                  end
                  // sender IP zero is never stored
                  if (req_sender_ip != '0) begin
                     state_in = SEQ_READ;
                  end
               end
            end
         end
         SEQ_READ: begin
            state_in = SEQ_COMPARE;
         end
         SEQ_COMPARE: begin
            if (free_now) begin
               free_found_in = 1'b1;
               free_way_in   = way_ff;
            end
            if (hit) begin
               state_in = SEQ_EMIT;
               if (learn_ff) begin
                  store_req.wr_en = 1'b1;
               end else begin
                  status_in = ST_HIT;
                  fmac_in   = store_rsp.mac;
               end
            end else if (last_way) begin
               state_in = SEQ_EMIT;
               if (learn_ff) begin
                  if (free_now) begin
                     store_req.wr_en = 1'b1;
                  end else if (free_found_ff) begin
                     store_req.wr_en   = 1'b1;
                     store_req.wr_addr = base + ADDR_W'(free_way_ff);
                  end else begin
                     status_in = ST_BUCKET_FULL;
                  end
               end
            end else begin
               way_in   = way_ff + WAY_W'(1);
               state_in = SEQ_READ;
            end
         end
         SEQ_EMIT: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_reply_dest_mac  = out_rmac_ff;
   assign rsp_reply_target_ip = out_rip_ff;
   assign rsp_found_mac       = out_fmac_ff;

endmodule

>>> bench/tb_arp_responder_with_hash_cache.sv
// ----------------------------------------------------------------------------
// tb_arp_responder_with_hash_cache
// Self-checking bench for the ARP responder and its hashed binding cache.
// A scoreboard keeps its own copy of the bindings and of the interface
// registers, predicts the one result of every accepted transaction and checks
// the results in order. Stimulus: a directed pass over packet checks, replies,
// overwrites and a full bucket, then three random phases with different
// register settings and with idling on either side, then on neither.
// ----------------------------------------------------------------------------
module tb_arp_responder_with_hash_cache;
   import arpr_pkg::*;

   localparam int RAND_PER_PHASE = 400;
   localparam int DRAIN_CYCLES   = 2 + 2 * WAYS + 4;
   localparam int CYCLE_LIMIT    = 600000;
   localparam int POOL_SIZE      = 40;

   typedef struct packed {
      logic              command;
      logic [LEN_W-1:0]  packet_length;
      logic [TYPE_W-1:0] proto_type;
      logic [ALEN_W-1:0] hw_len;
      logic [ALEN_W-1:0] proto_len;
      logic [OP_W-1:0]   opcode;
      logic [MAC_W-1:0]  sender_mac;
      logic [IP_W-1:0]   sender_ip;
      logic [IP_W-1:0]   target_ip;
   } arp_item_type;

   typedef struct packed {
      status_type       status;
      logic [MAC_W-1:0] dest_mac;
      logic [IP_W-1:0]  target_ip;
      logic [MAC_W-1:0] found_mac;
   } arp_result_type;

   class binding_scoreboard;
      logic [IP_W-1:0]  slot_ip  [SLOTS];
      logic [MAC_W-1:0] slot_mac [SLOTS];
      logic [IP_W-1:0]  own_ip;
      logic [MAC_W-1:0] own_mac;
      arp_result_type   awaited [$];
      int               failures;
      int               results;
      int               status_count [16];

      function new();
         foreach (slot_ip[i]) begin
            slot_ip[i]  = '0;
            slot_mac[i] = '0;
         end
         foreach (status_count[i]) status_count[i] = 0;
         own_ip   = '0;
         own_mac  = '0;
         failures = 0;
         results  = 0;
      endfunction

      function void write_reg(logic idx, logic [MAC_W-1:0] data);
         if (idx == CSR_OWN_IP) begin
            own_ip = data[IP_W-1:0];
         end else begin
            own_mac = data;
         end
      endfunction

      // Zero marks an empty way, so IP zero is accepted but never stored
      function bit learn_binding(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
         int base;
         int free_way;
         int w;
         if (ip == '0) return 1'b1;
         base     = int'(ip % BUCKETS) * WAYS;
         free_way = WAYS;
         for (w = 0; w < WAYS; w++) begin
            if (slot_ip[base + w] == ip) begin
               slot_mac[base + w] = mac;
               return 1'b1;
            end
            if (slot_ip[base + w] == '0 && free_way == WAYS) free_way = w;
         end
         if (free_way == WAYS) return 1'b0;
         slot_ip[base + free_way]  = ip;
         slot_mac[base + free_way] = mac;
         return 1'b1;
      endfunction

      function bit find_binding(input logic [IP_W-1:0] ip, output logic [MAC_W-1:0] mac);
         int base;
         int w;
         mac = '0;
         if (ip == '0) return 1'b0;
         base = int'(ip % BUCKETS) * WAYS;
         for (w = 0; w < WAYS; w++) begin
            if (slot_ip[base + w] == ip) begin
               mac = slot_mac[base + w];
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_input(arp_item_type it);
         arp_result_type   r;
         logic [MAC_W-1:0] m;
         r        = '0;
         r.status = ST_MISS;
         if (it.command == CMD_LOOKUP) begin
            if (find_binding(it.target_ip, m)) begin
               r.status    = ST_HIT;
               r.found_mac = m;
            end
         end else if (it.packet_length < ARP_MIN_LEN) begin
            r.status = ST_SHORT;
         end else if (it.proto_type != ETYPE_IPV4) begin
            r.status = ST_NOT_IPV4;
         end else if (it.hw_len != MAC_LEN) begin
            r.status = ST_BAD_HWLEN;
         end else if (it.proto_len != IPV4_LEN) begin
            r.status = ST_BAD_PLEN;
         end else if (it.opcode != OP_REQUEST && it.opcode != OP_REPLY) begin
            r.status = ST_BAD_OP;
         end else if (own_ip == '0) begin
            r.status = ST_NO_OWN_IP;
         end else if (it.opcode == OP_REQUEST) begin
            if (it.target_ip != own_ip) begin
               r.status = ST_NOT_FOR_US;
            end else begin
               // reply fields stand even when the bucket is full
               r.dest_mac  = it.sender_mac;
               r.target_ip = it.sender_ip;
               r.status    = learn_binding(it.sender_ip, it.sender_mac) ?
                             ST_REPLIED : ST_BUCKET_FULL;
            end
         end else begin
            r.status = learn_binding(it.sender_ip, it.sender_mac) ?
                       ST_LEARNED : ST_BUCKET_FULL;
         end
         awaited.push_back(r);
      endfunction

      function void check_result(logic [3:0] status, logic [MAC_W-1:0] dest_mac,
                                 logic [IP_W-1:0] target_ip, logic [MAC_W-1:0] found_mac);
         arp_result_type e;
         results++;
         if (awaited.size() == 0) begin
            $error("result with no transaction outstanding: status %0d", status);
            failures++;
            return;
         end
         e = awaited.pop_front();
         status_count[e.status]++;
         if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            failures++;
         end
         if (dest_mac !== e.dest_mac) begin
            $error("reply_dest_mac: expected %h, got %h", e.dest_mac, dest_mac);
            failures++;
         end
         if (target_ip !== e.target_ip) begin
            $error("reply_target_ip: expected %h, got %h", e.target_ip, target_ip);
            failures++;
         end
         if (found_mac !== e.found_mac) begin
            $error("found_mac: expected %h, got %h", e.found_mac, found_mac);
            failures++;
         end
      endfunction
   endclass

   logic              clock               = 1'b0;
   logic              reset               = 1'b1;
   logic              req_valid           = 1'b0;
   logic              req_stall;
   logic              req_command         = CMD_PACKET;
   logic [LEN_W-1:0]  req_packet_length   = '0;
   logic [TYPE_W-1:0] req_proto_type      = '0;
   logic [ALEN_W-1:0] req_hw_len          = '0;
   logic [ALEN_W-1:0] req_proto_len       = '0;
   logic [OP_W-1:0]   req_opcode          = '0;
   logic [MAC_W-1:0]  req_sender_mac      = '0;
   logic [IP_W-1:0]   req_sender_ip       = '0;
   logic [IP_W-1:0]   req_target_ip       = '0;
   logic              rsp_valid;
   logic              rsp_stall           = 1'b0;
   logic [3:0]        rsp_status;
   logic [MAC_W-1:0]  rsp_reply_dest_mac;
   logic [IP_W-1:0]   rsp_reply_target_ip;
   logic [MAC_W-1:0]  rsp_found_mac;
   logic              csr_valid           = 1'b0;
   logic              csr_ready;
   logic              csr_index           = CSR_OWN_IP;
   logic [MAC_W-1:0]  csr_wr_data         = '0;

   binding_scoreboard sb = new();
   int                req_gap_pct = 0;
   int                rsp_gap_pct = 0;
   int                cycles      = 0;
   logic [IP_W-1:0]   ip_pool [POOL_SIZE];

   arp_responder_with_hash_cache DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_packet_length   (req_packet_length),
      .req_proto_type      (req_proto_type),
      .req_hw_len          (req_hw_len),
      .req_proto_len       (req_proto_len),
      .req_opcode          (req_opcode),
      .req_sender_mac      (req_sender_mac),
      .req_sender_ip       (req_sender_ip),
      .req_target_ip       (req_target_ip),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_reply_dest_mac  (rsp_reply_dest_mac),
      .rsp_reply_target_ip (rsp_reply_target_ip),
      .rsp_found_mac       (rsp_found_mac),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_gap_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_status, rsp_reply_dest_mac, rsp_reply_target_ip, rsp_found_mac);
      end
   end

   function automatic logic [MAC_W-1:0] rand_mac();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic arp_item_type arp_packet(logic [OP_W-1:0] op, logic [MAC_W-1:0] smac,
                                               logic [IP_W-1:0] sip, logic [IP_W-1:0] tip);
      arp_item_type it;
      it.command       = CMD_PACKET;
      it.packet_length = LEN_W'($urandom_range(ARP_MIN_LEN, 65535));
      it.proto_type    = ETYPE_IPV4;
      it.hw_len        = MAC_LEN;
      it.proto_len     = IPV4_LEN;
      it.opcode        = op;
      it.sender_mac    = smac;
      it.sender_ip     = sip;
      it.target_ip     = tip;
      return it;
   endfunction

   function automatic arp_item_type arp_lookup(logic [IP_W-1:0] ip);
      arp_item_type it;
      it         = arp_packet(OP_REQUEST, rand_mac(), $urandom, ip);
      it.command = CMD_LOOKUP;
      return it;
   endfunction

   // IPs crowded into a few buckets so that hits and full buckets come often
   function automatic void refill_pool();
      logic [IP_W-1:0] hot [8];
      foreach (hot[b]) hot[b] = IP_W'($urandom_range(0, BUCKETS - 1));
      foreach (ip_pool[i]) begin
         ip_pool[i] = ($urandom & ~IP_W'(BUCKETS - 1)) | hot[$urandom_range(0, 7)];
      end
   endfunction

   function automatic logic [IP_W-1:0] pool_ip();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return '0;
      if (pick == 1) return $urandom;
      return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   function automatic arp_item_type random_item();
      arp_item_type it;
      int           pick;
      pick = $urandom_range(0, 99);
      it   = arp_packet(($urandom_range(0, 1) != 0) ? OP_REQUEST : OP_REPLY,
                        rand_mac(), pool_ip(), sb.own_ip);
      if (pick < 15) begin
         it.command       = 1'($urandom);
         it.packet_length = LEN_W'($urandom);
         it.proto_type    = TYPE_W'($urandom);
         it.hw_len        = ALEN_W'($urandom);
         it.proto_len     = ALEN_W'($urandom);
         it.opcode        = OP_W'($urandom);
         it.sender_ip     = $urandom;
         it.target_ip     = $urandom;
      end else if (pick < 27) begin
         case ($urandom_range(0, 4))
            0: it.packet_length = LEN_W'($urandom_range(0, ARP_MIN_LEN - 1));
            1: it.proto_type    = TYPE_W'($urandom);
            2: it.hw_len        = ALEN_W'($urandom);
            3: it.proto_len     = ALEN_W'($urandom);
            default: it.opcode  = OP_W'($urandom);
         endcase
      end else if (pick < 52) begin
         it = arp_lookup(pool_ip());
      end else if ($urandom_range(0, 4) == 0) begin
         it.target_ip = pool_ip();
      end
      return it;
   endfunction

   task automatic put_item(arp_item_type it);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= it.command;
      req_packet_length <= it.packet_length;
      req_proto_type    <= it.proto_type;
      req_hw_len        <= it.hw_len;
      req_proto_len     <= it.proto_len;
      req_opcode        <= it.opcode;
      req_sender_mac    <= it.sender_mac;
      req_sender_ip     <= it.sender_ip;
      req_target_ip     <= it.target_ip;
      do @(posedge clock); while (req_stall);
      sb.note_input(it);
   endtask

   // Upper data bits on the IP write must be dropped by the block
   task automatic configure(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
      logic [MAC_W-1:0] ip_data;
      ip_data     = {16'hA5C3, ip};
      csr_valid   <= 1'b1;
      csr_index   <= CSR_OWN_IP;
      csr_wr_data <= ip_data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(CSR_OWN_IP, ip_data);
      csr_index   <= CSR_OWN_MAC;
      csr_wr_data <= mac;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(CSR_OWN_MAC, mac);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      arp_item_type    it;
      arp_item_type    base_req;
      logic [IP_W-1:0] host;
      int              rejected;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // no own address yet: two lookups that miss, packet checks in order, then no-address status
      configure('0, '0);
      base_req = arp_packet(OP_REQUEST, 48'h0200_0000_0001, 32'hC0A8_0109, 32'hC0A8_0101);
      put_item(arp_lookup('0));
      put_item(arp_lookup('1));
      it = base_req;
      it.packet_length = '0;
      put_item(it);
      it.packet_length = LEN_W'(ARP_MIN_LEN - 1);
      put_item(it);
      it = base_req;
      it.packet_length = ARP_MIN_LEN;
      it.proto_type = 16'h0806;
      put_item(it);
      it = base_req;
      it.packet_length = '1;
      it.hw_len = '0;
      put_item(it);
      it.hw_len = '1;
      put_item(it);
      it = base_req;
      it.proto_len = '1;
      put_item(it);
      it = base_req;
      it.opcode = '0;
      put_item(it);
      it.opcode = 16'd3;
      put_item(it);
      it.opcode = '1;
      put_item(it);
      put_item(base_req);
      put_item(arp_packet(OP_REPLY, 48'h0200_0000_0002, 32'hC0A8_0107, '0));
      drain();

      configure(32'hC0A8_0101, '1);
      host = 32'hC0A8_0105;
      put_item(arp_packet(OP_REQUEST, rand_mac(), host, 32'hC0A8_0102));
      put_item(arp_packet(OP_REQUEST, '1, host, 32'hC0A8_0101));
      put_item(arp_lookup(host));
      put_item(arp_packet(OP_REPLY, 48'h0A0B_0C0D_0E0F, host, '0));
      put_item(arp_lookup(host));
      put_item(arp_packet(OP_REQUEST, '0, '0, 32'hC0A8_0101));
      put_item(arp_lookup('0));
      // same bucket: three more fit, the fourth finds it full
      for (int k = 1; k <= WAYS; k++) begin
         put_item(arp_packet(OP_REPLY, rand_mac(), host + IP_W'(k * BUCKETS), $urandom));
      end
      put_item(arp_packet(OP_REQUEST, rand_mac(), host + IP_W'(5 * BUCKETS), 32'hC0A8_0101));
      put_item(arp_lookup(host + IP_W'(WAYS * BUCKETS)));
      drain();

      configure(IP_W'($urandom | 1), rand_mac());
      req_gap_pct = 18;
      rsp_gap_pct = 72;
      refill_pool();
      repeat (RAND_PER_PHASE) put_item(random_item());
      drain();

      configure('1, rand_mac());
      req_gap_pct = 72;
      rsp_gap_pct = 18;
      refill_pool();
      repeat (RAND_PER_PHASE) put_item(random_item());
      drain();

      configure(IP_W'(1), '0);
      req_gap_pct = 0;
      rsp_gap_pct = 0;
      refill_pool();
      repeat (RAND_PER_PHASE) put_item(random_item());
      drain();

      rejected = 0;
      for (int s = ST_SHORT; s <= ST_NOT_FOR_US; s++) rejected += sb.status_count[s];
      $display("Checked %0d results over directed checks and three random phases.",
               sb.results);
      $display("Replies %0d, learns %0d, hits %0d, misses %0d, full buckets %0d, rejects %0d.",
               sb.status_count[ST_REPLIED], sb.status_count[ST_LEARNED],
               sb.status_count[ST_HIT], sb.status_count[ST_MISS],
               sb.status_count[ST_BUCKET_FULL], rejected);
      if (sb.failures == 0 && sb.awaited.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
